// ===== design/http_request_field_extractor_core_assert.svh =====
// Assertion macros used by the extractor core module.
// Each macro samples on clk and is disabled while rst is high.
`ifndef HTTP_REQUEST_FIELD_EXTRACTOR_CORE_ASSERT_SVH
`define HTTP_REQUEST_FIELD_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define HRFE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRFE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hrfe_pkg.sv =====
package hrfe_pkg;

  localparam int MAX_MSG_LEN_DEF = 256;
  localparam int HOST_MAX_DEF    = 127;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_U     = 8'h55;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_L     = 8'h4C;

  // "Host:" with the oldest byte high
  localparam logic [39:0] HOST_PAT = 40'h48_6F_73_74_3A;

  typedef enum logic [2:0] {
    METHOD_GET    = 3'd0,
    METHOD_POST   = 3'd1,
    METHOD_PUT    = 3'd2,
    METHOD_DELETE = 3'd3,
    METHOD_OTHER  = 3'd4
  } method_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_url;
    logic       is_host;
    logic       is_last;
    method_t    method;
    logic       url_ok;
    logic [7:0] url_length;
    logic [6:0] host_length;
    logic       too_long;
  } out_t;

  function automatic method_t pick_method(input logic [2:0][7:0] fb);
    method_t m;
    m = METHOD_OTHER;
    if (fb[0] == CHAR_G && fb[1] == CHAR_E && fb[2] == CHAR_T) begin
      m = METHOD_GET;
    end else if (fb[0] == CHAR_P && fb[1] == CHAR_O && fb[2] == CHAR_S) begin
      m = METHOD_POST;
    end else if (fb[0] == CHAR_P && fb[1] == CHAR_U && fb[2] == CHAR_T) begin
      m = METHOD_PUT;
    end else if (fb[0] == CHAR_D && fb[1] == CHAR_E && fb[2] == CHAR_L) begin
      m = METHOD_DELETE;
    end
    return m;
  endfunction

endpackage

// ===== design/hrfe_parse.sv =====
module hrfe_parse #(
  parameter int MAX_MSG_LEN = hrfe_pkg::MAX_MSG_LEN_DEF,
  parameter int HOST_MAX    = hrfe_pkg::HOST_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  hrfe_pkg::in_t in_req,
  output hrfe_pkg::out_t result
);

  localparam int PW = $clog2(MAX_MSG_LEN + 1);
  localparam int HW = $clog2(HOST_MAX + 1);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_COPY   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  logic [PW-1:0]   pos, pos_next;
  logic [2:0][7:0] first_bytes, first_bytes_next;
  logic [1:0]      space_count, space_count_next;
  logic [7:0]      url_count, url_count_next;
  logic [39:0]     lookback, lookback_next;
  phase_t          phase, phase_next;
  logic [HW-1:0]   host_count, host_count_next;
  logic            overflow, overflow_next;

  logic [7:0]      b;
  logic            is_url, is_host, ok;

  assign b = in_req.data_byte;

  always_comb begin
    pos_next         = pos;
    first_bytes_next = first_bytes;
    space_count_next = space_count;
    url_count_next   = url_count;
    phase_next       = phase;
    host_count_next  = host_count;
    overflow_next    = overflow;
    is_url           = 1'b0;
    is_host          = 1'b0;

    if (pos >= PW'(MAX_MSG_LEN)) begin
      overflow_next = 1'b1;
    end else begin
      if (pos < PW'(3)) begin
        first_bytes_next[pos[1:0]] = b;
      end
      pos_next = pos + PW'(1);
    end

    if (b == hrfe_pkg::CHAR_SPACE) begin
      if (space_count != 2'd2) begin
        space_count_next = space_count + 2'd1;
      end
    end else if (space_count == 2'd1) begin
      is_url = 1'b1;
      if (url_count != 8'hFF) begin
        url_count_next = url_count + 8'd1;
      end
    end

    unique case (phase)
      PH_COPY: begin
        if (b == hrfe_pkg::CHAR_CR || host_count >= HW'(HOST_MAX)) begin
          phase_next = PH_DONE;
        end else begin
          is_host         = 1'b1;
          host_count_next = host_count + HW'(1);
          if (host_count_next >= HW'(HOST_MAX)) begin
            phase_next = PH_DONE;
          end
        end
      end
      PH_SEARCH: begin
        if (b == hrfe_pkg::CHAR_SPACE && lookback == hrfe_pkg::HOST_PAT) begin
          phase_next = PH_COPY;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    lookback_next = {lookback[31:0], b};
  end

  assign ok = (space_count_next == 2'd2) && (url_count_next != 8'd0);

  always_comb begin
    result          = '0;
    result.out_byte = b;
    result.is_url   = is_url;
    result.is_host  = is_host;
    result.is_last  = in_req.last;
    result.method   = hrfe_pkg::METHOD_GET;
    if (in_req.last) begin
      result.method      = hrfe_pkg::pick_method(first_bytes_next);
      result.url_ok      = ok;
      result.url_length  = ok ? url_count_next : 8'd0;
      result.host_length = 7'(host_count_next);
      result.too_long    = overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_req.last)) begin
      pos         <= '0;
      first_bytes <= '0;
      space_count <= '0;
      url_count   <= '0;
      lookback    <= '0;
      phase       <= PH_SEARCH;
      host_count  <= '0;
      overflow    <= 1'b0;
    end else if (accept) begin
      pos         <= pos_next;
      first_bytes <= first_bytes_next;
      space_count <= space_count_next;
      url_count   <= url_count_next;
      lookback    <= lookback_next;
      phase       <= phase_next;
      host_count  <= host_count_next;
      overflow    <= overflow_next;
    end
  end

endmodule

// ===== design/http_request_field_extractor_core.sv =====
// Each accepted request byte has its result registered into out_req in the next cycle.
// Throughput: one byte per cycle; in_stall rises only while a result is
// held in the output register and out_stall is high.
// Reset (rst, synchronous): clears message state and the output valid;
// the first byte after reset starts a new message.
`include "http_request_field_extractor_core_assert.svh"

module http_request_field_extractor_core #(
  parameter int MAX_MSG_LEN = hrfe_pkg::MAX_MSG_LEN_DEF,
  parameter int HOST_MAX    = hrfe_pkg::HOST_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hrfe_pkg::in_t  in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output hrfe_pkg::out_t out_req
);

  logic           accept;
  hrfe_pkg::out_t result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  hrfe_parse #(
    .MAX_MSG_LEN(MAX_MSG_LEN),
    .HOST_MAX   (HOST_MAX)
  ) u_parse (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .in_req(in_req),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_req <= result;
    end
  end

  `HRFE_ASSERT_NXT(a_accept_to_out, accept,
    out_valid && out_req.out_byte == $past(in_req.data_byte), "result byte lost")
  `HRFE_ASSERT_IMP(a_summary_zero, out_valid && !out_req.is_last,
    out_req.method == hrfe_pkg::METHOD_GET && !out_req.url_ok &&
    out_req.url_length == 8'd0 && out_req.host_length == 7'd0 && !out_req.too_long,
    "summary set on inner byte")
  `HRFE_ASSERT_IMP(a_url_not_space, out_valid && out_req.is_url,
    out_req.out_byte != hrfe_pkg::CHAR_SPACE, "space tagged as url")
  `HRFE_ASSERT_IMP(a_url_ok_len, out_valid && out_req.url_ok,
    out_req.url_length != 8'd0, "url_ok with empty url")

endmodule
